// ===== design/mmn_pkg.sv =====
// ----------------------------------------------------------------------------
// mmn_pkg: shared types and constants
// Request and status codes, register indices, datapath command and status structs for the contrast stretch.
// ----------------------------------------------------------------------------
package mmn_pkg;

   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_READ = 1'b1;

   localparam logic STATUS_OK        = 1'b0;
   localparam logic STATUS_NOT_READY = 1'b1;

   localparam int CfgRegCount = 3;
   localparam logic [1:0] REG_FRAME_WIDTH    = 2'd0;
   localparam logic [1:0] REG_FRAME_HEIGHT   = 2'd1;
   localparam logic [1:0] REG_GRAYSCALE_MODE = 2'd2;

   localparam logic [7:0] FULL_SCALE = 8'd255;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;        // store the captured sample, update min/max
      logic rd_issue;    // set while the store read for the current plane is issued; unused by the datapath
      logic div_start;   // start a division on the returned sample
      logic [1:0] plane; // plane being read and whose result is being captured
      logic capture;     // capture the divider quotient for this plane
      logic advance;     // step the read position after the pixel
   } mmn_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic frame_loaded;
      logic div_done;
      logic last;
   } mmn_stat_type;

endpackage

// ===== design/mmn_if.sv =====
// ----------------------------------------------------------------------------
// mmn_req_if / mmn_rsp_if: valid-ready channels
// Request and response channels of the contrast stretch block.
// ----------------------------------------------------------------------------
interface mmn_req_if #(parameter int SAMPLE_BITS = 16);
   logic                   valid;
   logic                   ready;
   logic                   req_type;
   logic [SAMPLE_BITS-1:0] sample;
   modport source (output valid, req_type, sample, input ready);
   modport sink   (input valid, req_type, sample, output ready);
endinterface

interface mmn_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic       last_pixel;
   logic       status;
   modport source (output valid, red, green, blue, last_pixel, status, input ready);
   modport sink   (input valid, red, green, blue, last_pixel, status, output ready);
endinterface

// ===== design/minmax_normalise_planar_to_rgb_core.sv =====
// ----------------------------------------------------------------------------
// minmax_normalise_planar_to_rgb_core: min-max contrast stretch to RGB
// Loads one planar frame, then returns normalized pixels in raster order.
// ----------------------------------------------------------------------------
// A load transfer (req_type 0) stores one sample in planar order and updates
// the running minimum and maximum and returns nothing. A read transfer
// (req_type 1) returns one pixel. Each channel is 255*(v-min)/(max-min),
// rounded half up and clamped, computed by a shared restoring divider that
// produces one quotient bit per cycle. A color pixel runs the divider once
// per plane; a grayscale pixel runs it once. A read before the frame is fully
// loaded answers at once with status not_ready. The final pixel sets
// last_pixel and rearms loading. The sample store is a single-port RAM of
// 3*MAX_WIDTH*MAX_HEIGHT entries that needs no clearing after reset.
// Registers sit at byte addresses 0 (frame_width), 4 (frame_height) and
// 8 (grayscale_mode).
module minmax_normalise_planar_to_rgb_core import mmn_pkg::*; #(
   parameter int MAX_WIDTH   = 64,
   parameter int MAX_HEIGHT  = 64,
   parameter int SAMPLE_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   mmn_req_if.sink     req,
   mmn_rsp_if.source   rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   logic [6:0]   frame_width_ff, frame_height_ff;
   logic         gray_ff;
   logic [1:0]   reg_idx;
   mmn_cmd_type  cmd;
   mmn_stat_type stat;
   logic         rsp_zero, rsp_status, rsp_last;
   logic [7:0]   dp_red, dp_green, dp_blue;

   // Configuration registers: written on the access phase of an APB write.
   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= 7'd64;
         frame_height_ff <= 7'd64;
         gray_ff         <= 1'b0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr[1:0] == 2'b00) begin
         unique case (reg_idx)
            REG_FRAME_WIDTH:    frame_width_ff  <= csr_pwdata[6:0];
            REG_FRAME_HEIGHT:   frame_height_ff <= csr_pwdata[6:0];
            REG_GRAYSCALE_MODE: gray_ff         <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_FRAME_WIDTH:    csr_prdata = {25'd0, frame_width_ff};
         REG_FRAME_HEIGHT:   csr_prdata = {25'd0, frame_height_ff};
         REG_GRAYSCALE_MODE: csr_prdata = {31'd0, gray_ff};
         default:            csr_prdata = '0;
      endcase
   end

   mmn_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req.valid),
      .req_type       (req.req_type),
      .req_ready      (req.ready),
      .rsp_valid      (rsp.valid),
      .rsp_ready      (rsp.ready),
      .rsp_status     (rsp_status),
      .rsp_last       (rsp_last),
      .rsp_zero       (rsp_zero),
      .grayscale_mode (gray_ff),
      .stat           (stat),
      .cmd            (cmd)
   );

   mmn_datapath #(
      .MAX_WIDTH   (MAX_WIDTH),
      .MAX_HEIGHT  (MAX_HEIGHT),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .sample         (req.sample),
      .frame_width    (frame_width_ff),
      .frame_height   (frame_height_ff),
      .grayscale_mode (gray_ff),
      .red            (dp_red),
      .green          (dp_green),
      .blue           (dp_blue)
   );

   // A not_ready response shows zeros in every channel.
   assign rsp.red        = rsp_zero ? 8'd0 : dp_red;
   assign rsp.green      = rsp_zero ? 8'd0 : dp_green;
   assign rsp.blue       = rsp_zero ? 8'd0 : dp_blue;
   assign rsp.last_pixel = rsp_last;
   assign rsp.status     = rsp_status;
endmodule

// ===== design/mmn_ram.sv =====
// ----------------------------------------------------------------------------
// mmn_ram: generic single-port RAM
// One write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module mmn_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 12288
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule

// ===== design/mmn_divider.sv =====
// ----------------------------------------------------------------------------
// mmn_divider: restoring divider
// Computes (510*d + r) / (2*r), one quotient bit per cycle, saturated to 255.
// ----------------------------------------------------------------------------
module mmn_divider #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [SAMPLE_BITS:0] num_d,   // clamped offset, 0..range
   input  logic [SAMPLE_BITS:0] range,   // max - min; may be zero, then the datapath ignores the quotient
   output logic                 done,
   output logic [7:0]           quotient
);
   localparam int RW = SAMPLE_BITS + 1;
   localparam int NW = RW + 9;             // 510*d + r fits here
   localparam int CW = $clog2(NW + 1);

   logic [NW-1:0] num_ff, num_in;
   logic [RW+1:0] rem_ff, rem_in;
   logic [RW:0]   den_ff, den_in;
   logic [NW-1:0] q_ff, q_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [RW+1:0] trial;
   logic [NW-1:0] prod;

   assign prod = ({{(NW-RW){1'b0}}, num_d} << 9) - ({{(NW-RW){1'b0}}, num_d} << 1)
               + {{(NW-RW){1'b0}}, range};

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[RW:0], num_ff[NW-1]} - {1'b0, den_ff};
      if (start) begin
         num_in  = prod;
         den_in  = {range, 1'b0};
         rem_in  = '0;
         q_in    = '0;
         cnt_in  = CW'(NW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = num_ff << 1;
         if (!trial[RW+1]) begin
            rem_in = trial;
            q_in   = {q_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[RW:0], num_ff[NW-1]};
            q_in   = {q_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      q_ff   <= q_in;
   end

   assign done     = done_ff;
   assign quotient = (q_ff > NW'(255)) ? 8'd255 : q_ff[7:0];
endmodule

// ===== design/mmn_datapath.sv =====
// ----------------------------------------------------------------------------
// mmn_datapath: sample store, min/max tracking and normalization
// Holds the frame, the load and read positions, and the per-channel results.
// ----------------------------------------------------------------------------
module mmn_datapath import mmn_pkg::*; #(
   parameter int MAX_WIDTH   = 64,
   parameter int MAX_HEIGHT  = 64,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  mmn_cmd_type            cmd,
   output mmn_stat_type           stat,
   input  logic [SAMPLE_BITS-1:0] sample,
   input  logic [6:0]             frame_width,
   input  logic [6:0]             frame_height,
   input  logic                   grayscale_mode,
   output logic [7:0]             red,
   output logic [7:0]             green,
   output logic [7:0]             blue
);
   localparam int PLANE = MAX_WIDTH * MAX_HEIGHT;
   localparam int DEPTH = 3 * PLANE;
   localparam int AW    = $clog2(DEPTH);
   localparam int LW    = $clog2(DEPTH + 1);
   localparam int PW    = $clog2(PLANE + 1);
   localparam int XW    = $clog2(MAX_WIDTH + 1);
   localparam int YW    = $clog2(MAX_HEIGHT + 1);
   localparam int FW    = (XW > 7 ? XW : 7);
   localparam int HW    = (YW > 7 ? YW : 7);

   logic [XW-1:0]          w_dim;
   logic [YW-1:0]          h_dim;
   logic [FW-1:0]          fw_ext;
   logic [HW-1:0]          fh_ext;
   logic [PW-1:0]          pixels;
   logic [LW-1:0]          frame_size;
   logic [LW-1:0]          load_cnt_ff;
   logic [PW-1:0]          rd_idx_ff;
   logic [PW-1:0]          idx;
   logic signed [SAMPLE_BITS-1:0] min_ff, max_ff;
   logic signed [SAMPLE_BITS-1:0] s, rd_data;
   logic [AW-1:0]          addr;
   logic                   wr_en;
   logic signed [SAMPLE_BITS:0] range, diff, dclamp;
   logic                   div_done;
   logic [7:0]             quo, val;
   logic [7:0]             r_ff, g_ff, b_ff;
   logic [1:0]             plane_sel;

   assign fw_ext = FW'(frame_width);
   assign fh_ext = HW'(frame_height);
   assign w_dim = (fw_ext == '0) ? XW'(1) : (fw_ext > FW'(MAX_WIDTH))  ? XW'(MAX_WIDTH)
                : XW'(fw_ext);
   assign h_dim = (fh_ext == '0) ? YW'(1) : (fh_ext > HW'(MAX_HEIGHT)) ? YW'(MAX_HEIGHT)
                : YW'(fh_ext);

   // Frame sizes follow the registers directly, so every request sees the
   // current configuration.
   assign pixels     = PW'(w_dim) * PW'(h_dim);
   assign frame_size = grayscale_mode ? LW'(pixels) : LW'(3 * pixels);

   assign s   = sample;
   assign idx = (rd_idx_ff < pixels) ? rd_idx_ff : '0;
   assign wr_en = cmd.load && (load_cnt_ff < frame_size);
   assign plane_sel = cmd.plane;

   always_comb begin
      if (cmd.load) begin
         addr = AW'(load_cnt_ff);
      end else begin
         unique case (plane_sel)
            2'd1:    addr = AW'(pixels) + AW'(idx);
            2'd2:    addr = AW'({pixels, 1'b0}) + AW'(idx);
            default: addr = AW'(idx);
         endcase
      end
   end

   mmn_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .addr    (addr),
      .wr_data (s),
      .rd_data (rd_data)
   );

   assign range  = {max_ff[SAMPLE_BITS-1], max_ff} - {min_ff[SAMPLE_BITS-1], min_ff};
   assign diff   = {rd_data[SAMPLE_BITS-1], rd_data} - {min_ff[SAMPLE_BITS-1], min_ff};
   assign dclamp = (diff < 0) ? '0 : (diff > range) ? range : diff;

   mmn_divider #(.SAMPLE_BITS(SAMPLE_BITS)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .num_d    (dclamp),
      .range    (range),
      .done     (div_done),
      .quotient (quo)
   );

   assign val = (range == '0) ? 8'd0 : quo;

   always_ff @(posedge clock) begin
      if (reset) begin
         load_cnt_ff <= '0;
         rd_idx_ff   <= '0;
         min_ff      <= '0;
         max_ff      <= '0;
      end else begin
         if (wr_en) begin
            load_cnt_ff <= load_cnt_ff + 1'b1;
            if (load_cnt_ff == '0) begin
               min_ff <= s;
               max_ff <= s;
            end else begin
               if (s < min_ff) min_ff <= s;
               if (s > max_ff) max_ff <= s;
            end
         end
         if (cmd.advance) begin
            if (PW'(idx + 1'b1) >= pixels) begin
               rd_idx_ff   <= '0;
               load_cnt_ff <= '0;
            end else begin
               rd_idx_ff <= PW'(idx + 1'b1);
            end
         end
      end
      if (cmd.capture) begin
         unique case (plane_sel)
            2'd1:    g_ff <= val;
            2'd2:    b_ff <= val;
            default: begin
               r_ff <= val;
               if (grayscale_mode) begin
                  g_ff <= val;
                  b_ff <= val;
               end
            end
         endcase
      end
   end

   assign stat.frame_loaded = (load_cnt_ff >= frame_size);
   assign stat.div_done     = div_done;
   assign stat.last         = (PW'(idx + 1'b1) >= pixels);
   assign red   = r_ff;
   assign green = g_ff;
   assign blue  = b_ff;
endmodule

// ===== design/mmn_ctrl.sv =====
// ----------------------------------------------------------------------------
// mmn_ctrl: request sequencer
// Accepts requests, drives the datapath per plane and presents responses.
// ----------------------------------------------------------------------------
module mmn_ctrl import mmn_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_type,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic         rsp_status,
   output logic         rsp_last,
   output logic         rsp_zero,
   input  logic         grayscale_mode,
   input  mmn_stat_type stat,
   output mmn_cmd_type  cmd
);
   typedef enum logic [2:0] {
      S_IDLE, S_ISSUE, S_WAIT, S_START, S_DIV, S_RESP
   } state_type;

   state_type  state_ff;
   logic [1:0] plane_ff;
   logic       rsp_valid_ff, status_ff, last_ff, zero_ff;
   logic       accept;

   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign accept    = req_valid && req_ready;

   always_comb begin
      cmd           = '0;
      cmd.plane     = plane_ff;
      cmd.load      = accept && (req_type == REQ_LOAD);
      cmd.rd_issue  = (state_ff == S_ISSUE);
      cmd.div_start = (state_ff == S_START);
      cmd.capture   = (state_ff == S_DIV) && stat.div_done;
      cmd.advance   = (state_ff == S_RESP);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         plane_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         status_ff    <= STATUS_OK;
         last_ff      <= 1'b0;
         zero_ff      <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (accept && req_type == REQ_READ) begin
                  if (!stat.frame_loaded) begin
                     rsp_valid_ff <= 1'b1;
                     status_ff    <= STATUS_NOT_READY;
                     last_ff      <= 1'b0;
                     zero_ff      <= 1'b1;
                  end else begin
                     plane_ff <= '0;
                     state_ff <= S_ISSUE;
                  end
               end
            end
            S_ISSUE: state_ff <= S_WAIT;
            S_WAIT:  state_ff <= S_START;
            S_START: state_ff <= S_DIV;
            S_DIV: begin
               if (stat.div_done) begin
                  if (grayscale_mode || plane_ff == 2'd2) begin
                     state_ff <= S_RESP;
                  end else begin
                     plane_ff <= plane_ff + 1'b1;
                     state_ff <= S_ISSUE;
                  end
               end
            end
            S_RESP: begin
               rsp_valid_ff <= 1'b1;
               status_ff    <= STATUS_OK;
               last_ff      <= stat.last;
               zero_ff      <= 1'b0;
               state_ff     <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = status_ff;
   assign rsp_last   = last_ff;
   assign rsp_zero   = zero_ff;
endmodule

// ===== design/mmn_checker.sv =====
// ----------------------------------------------------------------------------
// mmn_checker: port-level assertions
// Checks response behavior of the contrast stretch core over time.
// ----------------------------------------------------------------------------
module mmn_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       req_type,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_red,
   input logic       rsp_last_pixel,
   input logic       rsp_status
);
   a_notready_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_red == 8'd0 && !rsp_last_pixel)
      else $error("not_ready response carries data");

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_red))
      else $error("stalled response changed");

   a_no_accept_while_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while a response waits");

   a_load_no_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_type && !rsp_valid |=> !rsp_valid)
      else $error("load produced a response");
endmodule

bind minmax_normalise_planar_to_rgb_core mmn_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req.valid),
   .req_ready      (req.ready),
   .req_type       (req.req_type),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .rsp_red        (rsp.red),
   .rsp_last_pixel (rsp.last_pixel),
   .rsp_status     (rsp.status)
);
